// File: rtl/bpa_pkg.sv
// Package for the bitmap page allocator: sizes, codes, payload structs,
// controller states and the command/status structs between the control
// and datapath modules. No dependencies.
package bpa_pkg;

   localparam int MAX_PAGES  = 32768;
   localparam int PAGE_SHIFT = 12;

   localparam int WORD_COUNT = (MAX_PAGES + 31) / 32;
   localparam int WORD_AW    = $clog2(WORD_COUNT);
   localparam int BASE_W     = WORD_AW + 5;
   localparam int CNT_W      = $clog2(MAX_PAGES + 1);
   localparam int PG_W       = 32 - PAGE_SHIFT;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_COUNT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_RESERVED = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_FIRST = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_SPAN  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_FIRST  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_PAGES  = 3'd5;

   localparam logic [1:0] KIND_INIT  = 2'd0;
   localparam logic [1:0] KIND_ALLOC = 2'd1;
   localparam logic [1:0] KIND_FREE  = 2'd2;

   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_OOM     = 2'd1;
   localparam logic [1:0] STATUS_IGNORED = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] page_address;
   } req_type;

   typedef struct packed {
      logic [31:0] result_address;
      logic [1:0]  status;
      logic [15:0] used_page_total;
      logic [15:0] free_page_total;
   } rsp_type;

   typedef struct packed {
      logic [15:0] page_count;
      logic [15:0] low_reserved_pages;
      logic [19:0] kernel_first_page;
      logic [15:0] kernel_span;
      logic [19:0] table_first_page;
      logic [15:0] table_pages;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SWEEP,
      ST_FLUSH,
      ST_ALLOC,
      ST_FREE_RD,
      ST_FREE_WR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic accept;
      logic sweep_step;
      logic sweep_clear;
      logic scan_step;
      logic free_rd;
      logic free_wr;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic sweep_last;
      logic scan_done;
      logic rsp_busy;
   } stat_type;

endpackage

// File: rtl/bpa_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module bpa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/bpa_ctrl.sv
// Sequencer for the page allocator: walks clear, init, allocate and free
// operations and issues datapath commands. Depends on bpa_pkg.
module bpa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_kind,
   input  bpa_pkg::stat_type stat,
   output bpa_pkg::cmd_type  cmd
);
   import bpa_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (stat.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_kind)
                  KIND_INIT:  state_in = ST_SWEEP;
                  KIND_ALLOC: state_in = ST_ALLOC;
                  KIND_FREE:  state_in = ST_FREE_RD;
                  default:    state_in = ST_DONE;
               endcase
            end
         end
         ST_SWEEP: begin
            if (stat.sweep_last) state_in = ST_FLUSH;
         end
         ST_FLUSH:   state_in = ST_DONE;
         ST_ALLOC: begin
            if (stat.scan_done) state_in = ST_DONE;
         end
         ST_FREE_RD: state_in = ST_FREE_WR;
         ST_FREE_WR: state_in = ST_DONE;
         ST_DONE: begin
            if (!stat.rsp_busy) state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.sweep_step  = 1'b1;
            cmd.sweep_clear = 1'b1;
         end
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_SWEEP:   cmd.sweep_step = 1'b1;
         ST_FLUSH:   ;
         ST_ALLOC:   cmd.scan_step = 1'b1;
         ST_FREE_RD: cmd.free_rd = 1'b1;
         ST_FREE_WR: cmd.free_wr = 1'b1;
         ST_DONE:    cmd.load_rsp = !stat.rsp_busy;
      endcase
   end

endmodule

// File: rtl/bpa_datapath.sv
// Datapath of the page allocator: bitmap RAM, sweep/scan pointers, used
// count, range masks and the result register. Depends on bpa_pkg, bpa_ram.
module bpa_datapath (
   input  logic              clock,
   input  logic              reset,
   input  bpa_pkg::cfg_type  cfg,
   input  bpa_pkg::cmd_type  cmd,
   output bpa_pkg::stat_type stat,
   input  bpa_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bpa_pkg::rsp_type  rsp_data
);
   import bpa_pkg::*;

   localparam int DIFF_W = CNT_W + 3;

   function automatic logic [5:0] clamp32(input logic signed [DIFF_W-1:0] d);
      logic [5:0] r;
      if (d < 0) begin
         r = 6'd0;
      end else if (d > 32) begin
         r = 6'd32;
      end else begin
         r = 6'(d);
      end
      return r;
   endfunction

   function automatic logic [31:0] ones(input logic [5:0] n);
      logic [31:0] r;
      if (n >= 6'd32) begin
         r = '1;
      end else begin
         r = (32'd1 << n) - 32'd1;
      end
      return r;
   endfunction

   function automatic logic signed [DIFF_W-1:0] sdiff(input logic [CNT_W-1:0] a,
                                                      input logic [BASE_W-1:0] b);
      return $signed(DIFF_W'(a)) - $signed(DIFF_W'(b));
   endfunction

   function automatic logic [5:0] popcount(input logic [31:0] w);
      logic [2:0] nib [8];
      logic [5:0] sum;
      for (int i = 0; i < 8; i++) begin
         nib[i] = 3'(w[4*i]) + 3'(w[4*i+1]) + 3'(w[4*i+2]) + 3'(w[4*i+3]);
      end
      sum = '0;
      for (int i = 0; i < 8; i++) begin
         sum = sum + 6'(nib[i]);
      end
      return sum;
   endfunction

   function automatic logic [CNT_W-1:0] clip(input logic [31:0] v,
                                             input logic [CNT_W-1:0] c);
      return (v > 32'(c)) ? c : CNT_W'(v);
   endfunction

   logic [WORD_AW-1:0] ptr_ff, ptr_in;
   logic [WORD_AW-1:0] chk_ff, chk_in;
   logic               chk_valid_ff, chk_valid_in;
   logic               pc_pend_ff, pc_pend_in;
   logic [31:0]        mask_ff, mask_in;
   logic [CNT_W-1:0]   used_ff, used_in;
   logic [CNT_W-1:0]   rs_ff [3];
   logic [CNT_W-1:0]   re_ff [3];
   logic [CNT_W-1:0]   rs_in [3];
   logic [CNT_W-1:0]   re_in [3];
   logic [PG_W-1:0]    page_ff, page_in;
   logic               addr_zero_ff, addr_zero_in;
   logic [31:0]        res_addr_ff, res_addr_in;
   logic [1:0]         status_ff, status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [CNT_W-1:0]   count;
   logic [BASE_W-1:0]  sweep_base;
   logic [BASE_W-1:0]  chk_base;
   logic [31:0]        sweep_mask;
   logic [31:0]        chk_vmask;
   logic [31:0]        free_bits;
   logic [31:0]        low_hot;
   logic [4:0]         low_idx;
   logic               found;
   logic               oom;
   logic               chk_last;
   logic               free_bad;
   logic [4:0]         free_bit;
   logic [31:0]        free_hot;
   logic [WORD_AW-1:0] free_word;
   logic [BASE_W-1:0]  new_page;

   logic               ram_we;
   logic [WORD_AW-1:0] ram_waddr;
   logic [31:0]        ram_wdata;
   logic [WORD_AW-1:0] ram_raddr;
   logic [31:0]        ram_rdata;

   bpa_ram #(
      .WIDTH(32),
      .DEPTH(WORD_COUNT)
   ) u_bitmap (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   assign count = (32'(cfg.page_count) > 32'(MAX_PAGES)) ? CNT_W'(MAX_PAGES)
                                                        : CNT_W'(cfg.page_count);

   assign sweep_base = {ptr_ff, 5'b0};
   assign chk_base   = {chk_ff, 5'b0};

   always_comb begin
      sweep_mask = '0;
      for (int i = 0; i < 3; i++) begin
         sweep_mask = sweep_mask | (ones(clamp32(sdiff(re_ff[i], sweep_base)))
                                    & ~ones(clamp32(sdiff(rs_ff[i], sweep_base))));
      end
   end

   // alloc scan: lowest clear bit below the page count in the checked word
   assign chk_vmask = ones(clamp32(sdiff(count, chk_base)));
   assign free_bits = ~ram_rdata & chk_vmask;
   assign low_hot   = free_bits & (~free_bits + 32'd1);
   always_comb begin
      low_idx = '0;
      for (int i = 0; i < 32; i++) begin
         if (low_hot[i]) low_idx = low_idx | 5'(i);
      end
   end
   assign oom      = 32'(chk_base) >= 32'(count);
   assign found    = chk_valid_ff && !oom && (free_bits != '0);
   assign chk_last = chk_ff == WORD_AW'(WORD_COUNT - 1);
   assign new_page = {chk_ff, low_idx};

   assign free_bad  = addr_zero_ff || (32'(page_ff) >= 32'(count));
   assign free_bit  = page_ff[4:0];
   assign free_hot  = 32'd1 << free_bit;
   assign free_word = page_ff[WORD_AW+4:5];

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = ptr_ff;
      ram_wdata = '0;
      ram_raddr = cmd.free_rd ? free_word : ptr_ff;
      if (cmd.sweep_step) begin
         ram_we    = 1'b1;
         ram_waddr = ptr_ff;
         ram_wdata = cmd.sweep_clear ? '0 : sweep_mask;
      end else if (cmd.scan_step && found) begin
         ram_we    = 1'b1;
         ram_waddr = chk_ff;
         ram_wdata = ram_rdata | low_hot;
      end else if (cmd.free_wr && !free_bad && ram_rdata[free_bit]) begin
         ram_we    = 1'b1;
         ram_waddr = free_word;
         ram_wdata = ram_rdata & ~free_hot;
      end
   end

   always_comb begin
      ptr_in       = ptr_ff;
      chk_in       = chk_ff;
      chk_valid_in = chk_valid_ff;
      pc_pend_in   = 1'b0;
      mask_in      = mask_ff;
      used_in      = used_ff;
      rs_in        = rs_ff;
      re_in        = re_ff;
      page_in      = page_ff;
      addr_zero_in = addr_zero_ff;
      res_addr_in  = res_addr_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;

      if (pc_pend_ff) begin
         used_in = used_ff + CNT_W'(popcount(mask_ff));
      end

      if (cmd.accept) begin
         ptr_in       = '0;
         chk_valid_in = 1'b0;
         page_in      = req_data.page_address[31:PAGE_SHIFT];
         addr_zero_in = req_data.page_address == '0;
         res_addr_in  = '0;
         status_in    = STATUS_DONE;
         if (req_data.kind == KIND_INIT) begin
            used_in  = '0;
            rs_in[0] = '0;
            re_in[0] = clip(32'(cfg.low_reserved_pages), count);
            rs_in[1] = clip(32'(cfg.kernel_first_page), count);
            re_in[1] = clip(32'(cfg.kernel_first_page) + 32'(cfg.kernel_span), count);
            rs_in[2] = clip(32'(cfg.table_first_page), count);
            re_in[2] = clip(32'(cfg.table_first_page) + 32'(cfg.table_pages), count);
         end
      end

      if (cmd.sweep_step) begin
         ptr_in     = ptr_ff + WORD_AW'(1);
         mask_in    = cmd.sweep_clear ? '0 : sweep_mask;
         pc_pend_in = 1'b1;
      end

      if (cmd.scan_step) begin
         ptr_in       = ptr_ff + WORD_AW'(1);
         chk_in       = ptr_ff;
         chk_valid_in = 1'b1;
         if (chk_valid_ff) begin
            if (found) begin
               used_in     = used_ff + CNT_W'(1);
               res_addr_in = 32'(new_page) << PAGE_SHIFT;
               status_in   = STATUS_DONE;
            end else if (oom || chk_last) begin
               status_in = STATUS_OOM;
            end
         end
      end

      if (cmd.free_rd && free_bad) begin
         status_in = STATUS_IGNORED;
      end

      if (cmd.free_wr && !free_bad && ram_rdata[free_bit]) begin
         used_in = used_ff - CNT_W'(1);
      end

      if (cmd.load_rsp) begin
         rsp_valid_in           = 1'b1;
         rsp_in.result_address  = res_addr_ff;
         rsp_in.status          = status_ff;
         rsp_in.used_page_total = 16'(used_ff);
         rsp_in.free_page_total = (count > used_ff) ? 16'(count - used_ff) : 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff       <= '0;
         chk_valid_ff <= 1'b0;
         pc_pend_ff   <= 1'b0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ptr_ff       <= ptr_in;
         chk_valid_ff <= chk_valid_in;
         pc_pend_ff   <= pc_pend_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      chk_ff       <= chk_in;
      mask_ff      <= mask_in;
      rs_ff        <= rs_in;
      re_ff        <= re_in;
      page_ff      <= page_in;
      addr_zero_ff <= addr_zero_in;
      res_addr_ff  <= res_addr_in;
      status_ff    <= status_in;
      rsp_ff       <= rsp_in;
   end

   assign stat.sweep_last = ptr_ff == WORD_AW'(WORD_COUNT - 1);
   assign stat.scan_done  = chk_valid_ff && (found || oom || chk_last);
   assign stat.rsp_busy   = rsp_valid_ff && !rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: rtl/bitmap_page_allocator.sv
// Top level of the bitmap page allocator: configuration registers and the
// controller/datapath pair. Depends on bpa_pkg, bpa_ctrl, bpa_datapath.
//
//   channel  ports                               beat
//   req      req_valid req_ready req_data        kind, page_address
//   rsp      rsp_valid rsp_ready rsp_data        address, status, used, free
//   csr      csr_we csr_index csr_wdata          one register write
//
// After reset a clearing pass writes every bitmap word, WORD_COUNT (1024)
// words, with req_ready low; csr writes are taken throughout.
// Per item: init writes one bitmap word per cycle over all WORD_COUNT words,
// then flushes; allocate checks words up to the first free page, the page
// count or the last word; free reads the word, then writes it back; an
// unknown kind goes straight to done. A beat is taken while the previous
// result waits; a stalled result holds the next item only in its done state.
module bitmap_page_allocator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  bpa_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output bpa_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  logic [bpa_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bpa_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import bpa_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   cmd_type  cmd;
   stat_type stat;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PAGE_COUNT:   cfg_in.page_count         = csr_wdata[15:0];
            CSR_LOW_RESERVED: cfg_in.low_reserved_pages = csr_wdata[15:0];
            CSR_KERNEL_FIRST: cfg_in.kernel_first_page  = csr_wdata[19:0];
            CSR_KERNEL_SPAN:  cfg_in.kernel_span        = csr_wdata[15:0];
            CSR_TABLE_FIRST:  cfg_in.table_first_page   = csr_wdata[19:0];
            CSR_TABLE_PAGES:  cfg_in.table_pages        = csr_wdata[15:0];
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.page_count         <= 16'd32768;
         cfg_ff.low_reserved_pages <= 16'd256;
         cfg_ff.kernel_first_page  <= 20'd256;
         cfg_ff.kernel_span        <= 16'd1;
         cfg_ff.table_first_page   <= 20'd512;
         cfg_ff.table_pages        <= 16'd9;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bpa_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_kind (req_data.kind),
      .stat     (stat),
      .cmd      (cmd)
   );

   bpa_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .cmd      (cmd),
      .stat     (stat),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

endmodule

// File: test/page_reply_checker.sv
// Reply checker for the bitmap page allocator: follows csr writes, keeps its own page
// bitmap and used count, predicts one reply per request beat and compares reply beats.
// Depends on bpa_pkg.
module page_reply_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  bpa_pkg::req_type               req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  bpa_pkg::rsp_type               rsp_data,
   input  logic                           csr_we,
   input  logic [bpa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bpa_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             mismatch_count,
   output int                             replies_pending,
   output int                             replies_checked,
   output int                             oom_replies
);
   import bpa_pkg::*;

   cfg_type     settings;
   logic [31:0] used_map [WORD_COUNT];
   int unsigned used_total;
   rsp_type     expected_replies [$];
   rsp_type     oldest;
   rsp_type     predicted;

   task automatic mark_span(input longint unsigned first, input longint unsigned span,
                            input longint unsigned limit);
      longint unsigned last;
      last = first + span;
      if (last > limit) last = limit;
      for (longint unsigned pg = first; pg < last; pg++) begin
         if (!used_map[pg / 32][pg % 32]) begin
            used_map[pg / 32][pg % 32] = 1'b1;
            used_total++;
         end
      end
   endtask

   task automatic apply_request(input req_type req, output rsp_type reply);
      int unsigned limit;
      int unsigned pg;
      int          w;
      int          b;
      reply = '0;
      limit = (settings.page_count > MAX_PAGES) ? MAX_PAGES : settings.page_count;
      case (req.kind)
         KIND_INIT: begin
            foreach (used_map[i]) used_map[i] = '0;
            used_total = 0;
            mark_span(0, settings.low_reserved_pages, limit);
            mark_span(settings.kernel_first_page, settings.kernel_span, limit);
            mark_span(settings.table_first_page, settings.table_pages, limit);
         end
         KIND_ALLOC: begin
            reply.status = STATUS_OOM;
            for (w = 0; w < WORD_COUNT && w * 32 < limit; w++) begin
               if (used_map[w] != '1) begin
                  b = 0;
                  while (used_map[w][b]) b++;
                  pg = w * 32 + b;
                  if (pg < limit) begin
                     used_map[w][b] = 1'b1;
                     used_total++;
                     reply.result_address = pg << PAGE_SHIFT;
                     reply.status = STATUS_DONE;
                  end
                  break;
               end
            end
         end
         KIND_FREE: begin
            pg = req.page_address >> PAGE_SHIFT;
            if (req.page_address == 0 || pg >= limit) begin
               reply.status = STATUS_IGNORED;
            end else if (used_map[pg / 32][pg % 32]) begin
               used_map[pg / 32][pg % 32] = 1'b0;
               used_total--;
            end
         end
         default: ;
      endcase
      reply.used_page_total = 16'(used_total);
      reply.free_page_total = (limit > used_total) ? 16'(limit - used_total) : 16'd0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         settings = '{16'd32768, 16'd256, 20'd256, 16'd1, 20'd512, 16'd9};
         foreach (used_map[i]) used_map[i] = '0;
         used_total = 0;
         expected_replies.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_PAGE_COUNT:   settings.page_count         = csr_wdata[15:0];
               CSR_LOW_RESERVED: settings.low_reserved_pages = csr_wdata[15:0];
               CSR_KERNEL_FIRST: settings.kernel_first_page  = csr_wdata[19:0];
               CSR_KERNEL_SPAN:  settings.kernel_span        = csr_wdata[15:0];
               CSR_TABLE_FIRST:  settings.table_first_page   = csr_wdata[19:0];
               CSR_TABLE_PAGES:  settings.table_pages        = csr_wdata[15:0];
               default: ;
            endcase
         end
         // reply first: a beat accepted this edge cannot be answered this edge
         if (rsp_valid && rsp_ready) begin
            replies_checked++;
            if (expected_replies.size() == 0) begin
               $error("reply beat with nothing expected: %p", rsp_data);
               mismatch_count++;
            end else begin
               oldest = expected_replies.pop_front();
               if (oldest.status == STATUS_OOM) oom_replies++;
               if (rsp_data.result_address !== oldest.result_address) begin
                  $error("result_address: expected %h, got %h",
                         oldest.result_address, rsp_data.result_address);
                  mismatch_count++;
               end
               if (rsp_data.status !== oldest.status) begin
                  $error("status: expected %0d, got %0d", oldest.status, rsp_data.status);
                  mismatch_count++;
               end
               if (rsp_data.used_page_total !== oldest.used_page_total) begin
                  $error("used_page_total: expected %0d, got %0d",
                         oldest.used_page_total, rsp_data.used_page_total);
                  mismatch_count++;
               end
               if (rsp_data.free_page_total !== oldest.free_page_total) begin
                  $error("free_page_total: expected %0d, got %0d",
                         oldest.free_page_total, rsp_data.free_page_total);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            apply_request(req_data, predicted);
            expected_replies.push_back(predicted);
         end
      end
      replies_pending = expected_replies.size();
   end

endmodule

// File: test/bitmap_page_allocator_tb.sv
// Testbench top for the bitmap page allocator: clock, reset, csr settings, request
// beats with idling and a reply stall stretch, watchdog and verdict.
// Depends on bpa_pkg, bitmap_page_allocator and page_reply_checker.
module bitmap_page_allocator_tb;
   import bpa_pkg::*;

   localparam logic [1:0] KIND_UNKNOWN = 2'd3;
   localparam int STALL_LIMIT = 20000;
   localparam int PHASES      = 7;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int mismatch_count;
   int replies_pending;
   int replies_checked;
   int oom_replies;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_left;
   int requests_sent;
   int settings_loaded;
   int quiet_cycles;

   cfg_type phase_cfg   [PHASES];
   int      phase_items [PHASES];
   bit      phase_init  [PHASES];

   bitmap_page_allocator uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   page_reply_checker reply_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .mismatch_count(mismatch_count), .replies_pending(replies_pending),
      .replies_checked(replies_checked), .oom_replies(oom_replies)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("== FAIL ==");
      $finish;
   end

   task automatic send_request(input logic [1:0] op, input logic [31:0] address);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{kind: op, page_address: address};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      requests_sent++;
   endtask

   // drops valid, then waits for every predicted reply to come back
   task automatic finish_pending();
      req_valid <= 1'b0;
      @(negedge clock);
      while (replies_pending != 0) @(negedge clock);
   endtask

   // upper bits of the 16-bit registers get junk that must be dropped
   task automatic load_settings(input cfg_type c);
      csr_we    <= 1'b1;
      csr_index <= CSR_PAGE_COUNT;
      csr_wdata <= {4'($urandom), c.page_count};
      @(negedge clock);
      csr_index <= CSR_LOW_RESERVED;
      csr_wdata <= {4'($urandom), c.low_reserved_pages};
      @(negedge clock);
      csr_index <= CSR_KERNEL_FIRST;
      csr_wdata <= c.kernel_first_page;
      @(negedge clock);
      csr_index <= CSR_KERNEL_SPAN;
      csr_wdata <= {4'($urandom), c.kernel_span};
      @(negedge clock);
      csr_index <= CSR_TABLE_FIRST;
      csr_wdata <= c.table_first_page;
      @(negedge clock);
      csr_index <= CSR_TABLE_PAGES;
      csr_wdata <= {4'($urandom), c.table_pages};
      @(negedge clock);
      csr_we <= 1'b0;
      settings_loaded++;
   endtask

   task automatic random_request(input int unsigned count_reg);
      int unsigned limit;
      int unsigned pick;
      int unsigned span;
      limit = (count_reg > MAX_PAGES) ? MAX_PAGES : count_reg;
      span  = (limit > 1100) ? 1100 : limit + 1;
      pick  = $urandom_range(99);
      if (pick < 3)
         send_request(KIND_INIT, $urandom);
      else if (pick < 5)
         send_request(KIND_UNKNOWN, $urandom);
      else if (pick < 7)
         send_request(KIND_FREE, 32'd0);
      else if (pick < 10)
         send_request(KIND_FREE, $urandom);
      else if (pick < 55)
         send_request(KIND_ALLOC, $urandom);
      else
         send_request(KIND_FREE, ($urandom_range(span) << PAGE_SHIFT) | $urandom_range(4095));
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_data        = '0;
      csr_we          = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      send_idle_pct   = 24;
      recv_idle_pct   = 68;
      hold_left       = 0;
      requests_sent   = 0;
      settings_loaded = 0;

      phase_cfg[0] = '{16'd64,    16'd4,     20'd10,      16'd3,     20'd12,      16'd2};
      phase_cfg[1] = '{16'd200,   16'd0,     20'd0,       16'd0,     20'd0,       16'd0};
      phase_cfg[2] = '{16'd100,   16'd32768, 20'd5,       16'd5,     20'd1048575, 16'd32768};
      phase_cfg[3] = '{16'd1,     16'd0,     20'd1048575, 16'd65535, 20'd0,       16'd65535};
      phase_cfg[4] = '{16'd32768, 16'd256,   20'd256,     16'd1,     20'd512,     16'd9};
      phase_cfg[5] = '{16'd0,     16'd7,     20'd3,       16'd2,     20'd1,       16'd1};
      phase_cfg[6] = '{16'd48,    16'd40,    20'd47,      16'd32768, 20'd20,      16'd10};
      phase_items  = '{300, 300, 200, 60, 300, 30, 340};
      phase_init   = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: 16 pages, reserved 0-3, kernel 6-8, table 8-15 clipped
      load_settings('{16'd16, 16'd4, 20'd6, 16'd3, 20'd8, 16'd9});
      send_request(KIND_ALLOC, 32'd0);
      send_request(KIND_FREE, 32'd0);
      send_request(KIND_UNKNOWN, 32'hFFFF_FFFF);
      send_request(KIND_INIT, 32'd0);
      send_request(KIND_ALLOC, 32'd0);
      send_request(KIND_ALLOC, 32'd0);
      send_request(KIND_ALLOC, 32'd0);
      send_request(KIND_FREE, 32'h0000_5000);
      send_request(KIND_FREE, 32'h0000_5123);
      send_request(KIND_FREE, 32'h0001_0000);
      send_request(KIND_FREE, 32'hFFFF_FFFF);
      send_request(KIND_FREE, 32'h0000_0FFF);
      send_request(KIND_ALLOC, 32'd0);
      send_request(KIND_ALLOC, 32'd0);
      finish_pending();
      // count drops below set bits: free total saturates
      load_settings('{16'd8, 16'd4, 20'd6, 16'd3, 20'd8, 16'd9});
      send_request(KIND_ALLOC, 32'd0);
      send_request(KIND_FREE, 32'h0000_A000);
      send_request(KIND_UNKNOWN, 32'd0);
      finish_pending();
      // count above the maximum is clipped
      load_settings('{16'd65535, 16'd4, 20'd6, 16'd3, 20'd8, 16'd9});
      send_request(KIND_ALLOC, 32'd0);
      send_request(KIND_FREE, 32'h0001_0000);
      send_request(KIND_INIT, 32'd0);
      send_request(KIND_ALLOC, 32'd0);

      for (int ph = 0; ph < PHASES; ph++) begin
         finish_pending();
         load_settings(phase_cfg[ph]);
         case (ph * 3 / PHASES)
            0: begin
               send_idle_pct = 24;
               recv_idle_pct = 68;
            end
            1: begin
               send_idle_pct = 68;
               recv_idle_pct = 24;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         if (phase_init[ph]) send_request(KIND_INIT, 32'd0);
         for (int n = 0; n < phase_items[ph]; n++) begin
            if (ph == 0 && n == 100) hold_left = 400;
            if (ph == 4 && n == 150) finish_pending();
            random_request(phase_cfg[ph].page_count);
         end
      end

      finish_pending();
      repeat (64) @(negedge clock);
      $display("Covered %0d requests over %0d csr settings: init, allocate, free, unknown kind.",
               requests_sent, settings_loaded);
      $display("Checked %0d replies, %0d of them out of memory.", replies_checked, oom_replies);
      if (mismatch_count == 0 && replies_pending == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// File: files.f
rtl/bpa_pkg.sv
rtl/bpa_ram.sv
rtl/bpa_ctrl.sv
rtl/bpa_datapath.sv
rtl/bitmap_page_allocator.sv
test/page_reply_checker.sv
test/bitmap_page_allocator_tb.sv
